// File: sv/akcd_pkg.sv
// shared types and constants for the aged key cache directory
// no dependencies; used by the top level and its checker

package akcd_pkg;

   localparam int SLOTS_DEFAULT = 64;
   localparam int KEY_W         = 64;
   localparam int AGE_W         = 32;
   localparam int SLOT_IDX_W    = 6;
   localparam int CFG_W         = 7;

   localparam logic [CFG_W-1:0] ENTRIES_RESET = 7'd64;

   localparam logic MODE_LOOKUP = 1'b0;
   localparam logic MODE_ADD    = 1'b1;

   typedef struct packed {
      logic                    mode;
      logic signed [KEY_W-1:0] key;
   } req_item_type;

   typedef struct packed {
      logic                  hit;
      logic [SLOT_IDX_W-1:0] slot_index;
   } rsp_item_type;

   // one directory slot as held in the slot memory
   typedef struct packed {
      logic             valid;
      logic [AGE_W-1:0] age;
      logic [KEY_W-1:0] key;
   } slot_word_type;

endpackage

// File: sv/aged_key_cache_directory_unit.sv
// fully associative key directory with per-slot age counters
// depends on akcd_pkg (types and constants)

// Usage: after reset the block sweeps its slot memory clear, one slot per
// clock, with busy high; configuration writes are still taken.
// An item is taken when start is high and busy is low. A lookup walks the
// active slots once through the single read port of the slot memory. An
// add walks them to find the first equal key and stops there; when there
// is none it walks them a second time for the replacement scan, which
// stops at the first empty slot; then the commit state writes the chosen
// slot. The result is shown on rsp_data for exactly one cycle with
// rsp_valid high and must be taken then: the receiver cannot hold it off.
// busy falls in that same cycle, so the next item can be started while
// the result is on the ports.

module aged_key_cache_directory_unit #(
   parameter int SLOTS = akcd_pkg::SLOTS_DEFAULT
) (
   input  logic                         clock,
   input  logic                         reset,
   // item request
   input  logic                         start,
   output logic                         busy,
   input  akcd_pkg::req_item_type       req_data,
   // result strobe
   output logic                         rsp_valid,
   output akcd_pkg::rsp_item_type       rsp_data,
   // entries_in_use register write
   input  logic                         csr_valid,
   output logic                         csr_ready,
   input  logic [akcd_pkg::CFG_W-1:0]   csr_data
);

   localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int NW = ($clog2(SLOTS + 1) > akcd_pkg::CFG_W) ?
                       $clog2(SLOTS + 1) : akcd_pkg::CFG_W;

   typedef enum logic [5:0] {
      ST_CLEAR  = 6'b000001,
      ST_IDLE   = 6'b000010,
      ST_LOOK   = 6'b000100,
      ST_MATCH  = 6'b001000,
      ST_SCAN   = 6'b010000,
      ST_COMMIT = 6'b100000
   } state_type;

   // slot memory, one read and one write port
   akcd_pkg::slot_word_type slot_mem [SLOTS];

   state_type                    state_ff, state_in;
   logic [IW-1:0]                clr_idx_ff, clr_idx_in;
   logic [akcd_pkg::CFG_W-1:0]   entries_ff;
   logic [IW-1:0]                last_idx_ff, last_idx_in;
   logic                         issue_on_ff, issue_on_in;
   logic [IW-1:0]                issue_idx_ff, issue_idx_in;
   logic                         data_vld_ff, data_vld_in;
   logic [IW-1:0]                data_idx_ff, data_idx_in;
   akcd_pkg::slot_word_type      rd_data_ff;
   logic [akcd_pkg::KEY_W-1:0]   key_ff, key_in;
   logic                         found_ff, found_in;
   logic [IW-1:0]                hit_idx_ff, hit_idx_in;
   logic                         hit_valid_ff, hit_valid_in;
   logic [akcd_pkg::AGE_W-1:0]   run_max_ff, run_max_in;
   logic [IW-1:0]                pick_idx_ff, pick_idx_in;
   logic [akcd_pkg::AGE_W-1:0]   pick_age_ff, pick_age_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   akcd_pkg::rsp_item_type       rsp_ff, rsp_in;

   logic                         rd_en;
   logic                         wr_en;
   logic [IW-1:0]                wr_addr;
   akcd_pkg::slot_word_type      wr_word;

   // shared slot unit: one key compare, one saturating increment, one age compare
   logic                         key_eq;
   logic [akcd_pkg::AGE_W-1:0]   age_inc;
   logic                         age_ge_max;
   logic                         at_last;
   logic [NW-1:0]                cfg_ext;
   logic [IW-1:0]                limit_idx;
   logic                         pass_state;

   assign key_eq     = (rd_data_ff.key == key_ff);
   assign age_inc    = (rd_data_ff.age == '1) ? rd_data_ff.age
                                              : rd_data_ff.age + 1'b1;
   assign age_ge_max = (run_max_ff <= rd_data_ff.age);
   assign at_last    = (data_idx_ff == last_idx_ff);
   assign pass_state = (state_ff == ST_LOOK) || (state_ff == ST_MATCH) ||
                       (state_ff == ST_SCAN);

   // active slot count clamped to 1..SLOTS, held as its last index
   assign cfg_ext = NW'(entries_ff);
   always_comb begin
      priority if (cfg_ext == '0) begin
         limit_idx = '0;
      end else if (cfg_ext > NW'(SLOTS)) begin
         limit_idx = IW'(SLOTS - 1);
      end else begin
         limit_idx = IW'(cfg_ext - NW'(1));
      end
   end

   assign busy      = (state_ff != ST_IDLE);
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   always_comb begin
      state_in     = state_ff;
      clr_idx_in   = clr_idx_ff;
      last_idx_in  = last_idx_ff;
      issue_on_in  = issue_on_ff;
      issue_idx_in = issue_idx_ff;
      key_in       = key_ff;
      found_in     = found_ff;
      hit_idx_in   = hit_idx_ff;
      hit_valid_in = hit_valid_ff;
      run_max_in   = run_max_ff;
      pick_idx_in  = pick_idx_ff;
      pick_age_in  = pick_age_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;
      wr_en        = 1'b0;
      wr_addr      = data_idx_ff;
      wr_word      = rd_data_ff;

      // read issue runs ahead of the processing: a read is processed in the cycle after it is issued
      rd_en = pass_state && issue_on_ff;
      if (rd_en) begin
         issue_idx_in = issue_idx_ff + 1'b1;
         if (issue_idx_ff == last_idx_ff) begin
            issue_on_in = 1'b0;
         end
      end
      data_vld_in = rd_en;
      data_idx_in = issue_idx_ff;

      unique case (state_ff)
         ST_CLEAR: begin
            wr_en   = 1'b1;
            wr_addr = clr_idx_ff;
            wr_word = '0;
            clr_idx_in = clr_idx_ff + 1'b1;
            if (clr_idx_ff == IW'(SLOTS - 1)) begin
               state_in = ST_IDLE;
            end
         end

         ST_IDLE: begin
            if (start) begin
               key_in       = req_data.key;
               last_idx_in  = limit_idx;
               issue_on_in  = 1'b1;
               issue_idx_in = '0;
               found_in     = 1'b0;
               hit_idx_in   = '0;
               hit_valid_in = 1'b0;
               state_in     = (req_data.mode == akcd_pkg::MODE_ADD) ? ST_MATCH : ST_LOOK;
            end
         end

         ST_LOOK: begin
            if (data_vld_ff) begin
               // age every searched slot, a matching slot restarts at zero
               wr_en       = 1'b1;
               wr_word.age = key_eq ? '0 : age_inc;
               if (key_eq) begin
                  found_in     = 1'b1;
                  hit_idx_in   = data_idx_ff;
                  hit_valid_in = rd_data_ff.valid;
               end
               if (at_last) begin
                  rsp_valid_in = 1'b1;
                  if (found_in && hit_valid_in) begin
                     rsp_in.hit        = 1'b1;
                     rsp_in.slot_index = akcd_pkg::SLOT_IDX_W'(hit_idx_in);
                  end else begin
                     rsp_in.hit        = 1'b0;
                     rsp_in.slot_index = '0;
                  end
                  state_in = ST_IDLE;
               end
            end
         end

         ST_MATCH: begin
            if (data_vld_ff) begin
               if (key_eq) begin
                  // first equal key wins, valid or not
                  pick_idx_in = data_idx_ff;
                  pick_age_in = rd_data_ff.age;
                  state_in    = ST_COMMIT;
               end else if (at_last) begin
                  issue_on_in  = 1'b1;
                  issue_idx_in = '0;
                  data_vld_in  = 1'b0;
                  run_max_in   = '0;
                  pick_idx_in  = '0;
                  pick_age_in  = '0;
                  state_in     = ST_SCAN;
               end
            end
         end

         ST_SCAN: begin
            if (data_vld_ff) begin
               if (!rd_data_ff.valid) begin
                  // first empty slot ends the scan
                  pick_idx_in = data_idx_ff;
                  pick_age_in = rd_data_ff.age;
                  state_in    = ST_COMMIT;
               end else begin
                  if (age_ge_max) begin
                     wr_en       = 1'b1;
                     wr_word.age = age_inc;
                     run_max_in  = age_inc;
                     pick_idx_in = data_idx_ff;
                     pick_age_in = age_inc;
                  end
                  if (at_last) begin
                     state_in = ST_COMMIT;
                  end
               end
            end
         end

         ST_COMMIT: begin
            wr_en         = 1'b1;
            wr_addr       = pick_idx_ff;
            wr_word.valid = 1'b1;
            wr_word.age   = pick_age_ff;
            wr_word.key   = key_ff;
            rsp_valid_in      = 1'b1;
            rsp_in.hit        = 1'b1;
            rsp_in.slot_index = akcd_pkg::SLOT_IDX_W'(pick_idx_ff);
            state_in = ST_IDLE;
         end

         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   // slot memory ports
   always_ff @(posedge clock) begin
      if (wr_en) begin
         slot_mem[wr_addr] <= wr_word;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= slot_mem[issue_idx_ff];
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_idx_ff   <= '0;
         entries_ff   <= akcd_pkg::ENTRIES_RESET;
         issue_on_ff  <= 1'b0;
         data_vld_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_idx_ff   <= clr_idx_in;
         issue_on_ff  <= issue_on_in;
         data_vld_ff  <= data_vld_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            entries_ff <= csr_data;
         end
      end
   end

   // working registers of the current item
   always_ff @(posedge clock) begin
      last_idx_ff  <= last_idx_in;
      issue_idx_ff <= issue_idx_in;
      data_idx_ff  <= data_idx_in;
      key_ff       <= key_in;
      found_ff     <= found_in;
      hit_idx_ff   <= hit_idx_in;
      hit_valid_ff <= hit_valid_in;
      run_max_ff   <= run_max_in;
      pick_idx_ff  <= pick_idx_in;
      pick_age_ff  <= pick_age_in;
      rsp_ff       <= rsp_in;
   end

endmodule

// File: sv/akcd_checker.sv
// port-level checks for the aged key cache directory, bound to the top level
// depends on akcd_pkg and aged_key_cache_directory_unit

module akcd_checker (
   input logic                   clock,
   input logic                   reset,
   input logic                   start,
   input logic                   busy,
   input logic                   rsp_valid,
   input akcd_pkg::rsp_item_type rsp_data
);

   // a taken item makes the block busy
   a_start_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("item taken but busy stayed low");

   // a result ends the item, so the block is free while it is shown
   a_rsp_free: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("result shown while still busy");

   // an item never ends in the cycle it is taken, so results never come back to back
   a_rsp_gap: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("two results in consecutive cycles");

   // a miss reports slot zero
   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.hit |-> rsp_data.slot_index == '0)
      else $error("miss with nonzero slot index");

endmodule

bind aged_key_cache_directory_unit akcd_checker u_akcd_checker (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .rsp_valid (rsp_valid),
   .rsp_data  (rsp_data)
);
